[hdl/maze_bt_pkg.sv]
// ----------------------------------------------------------------------------
// maze_bt_pkg
// shared types, codes and constants of the maze explorer with backtracking
// ----------------------------------------------------------------------------
package maze_bt_pkg;

   // field widths
   localparam int DIST_W     = 10;
   localparam int MOVE_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = DIST_W;

   // default store depths
   localparam int LOG_DEPTH_DEF      = 32;
   localparam int JUNCTION_DEPTH_DEF = 32;

   // results of one transaction are capped
   localparam int MAX_RESULTS = 34;
   localparam int RES_CNT_W   = 6;

   // limit register reset values
   localparam logic [DIST_W-1:0] BLOCKED_LIMIT_RST = 10'd10;
   localparam logic [DIST_W-1:0] FAR_LIMIT_RST     = 10'd75;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKED_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_LIMIT     = 1'b1;

   typedef enum logic [MOVE_W-1:0] {
      MV_NONE,
      MV_FWD,
      MV_LEFT,
      MV_RIGHT,
      MV_BACK
   } move_type;

   typedef enum logic [1:0] {
      LG_NONE,
      LG_FWD,
      LG_LEFT,
      LG_RIGHT
   } log_code_type;

   typedef enum logic [1:0] {
      MK_NONE,
      MK_FWD,
      MK_LEFT,
      MK_RIGHT
   } mark_type;

   typedef enum logic [1:0] {
      CL_BLOCKED,
      CL_OPEN,
      CL_FAR
   } class_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_NONE,
      ST_TURN,
      ST_FWD,
      ST_BT_WAIT,
      ST_BT_START,
      ST_BT_LOOP,
      ST_BT_SRD,
      ST_BT_TAIL,
      ST_FINISH
   } state_type;

   // far test first, then blocked
   function automatic class_type classify(
      input logic [DIST_W-1:0] dist_cm,
      input logic [DIST_W-1:0] blocked_lim,
      input logic [DIST_W-1:0] far_lim
   );
      class_type cls;
      if (dist_cm > far_lim) begin
         cls = CL_FAR;
      end else if (dist_cm <= blocked_lim) begin
         cls = CL_BLOCKED;
      end else begin
         cls = CL_OPEN;
      end
      return cls;
   endfunction

endpackage

[hdl/maze_bt_if.sv]
// ----------------------------------------------------------------------------
// maze_bt_req_if / maze_bt_rsp_if
// valid/ready channels carrying wall distances in and moves out
// ----------------------------------------------------------------------------
interface maze_bt_req_if;
   logic                            valid;
   logic                            ready;
   logic [maze_bt_pkg::DIST_W-1:0]  front_cm;
   logic [maze_bt_pkg::DIST_W-1:0]  left_cm;
   logic [maze_bt_pkg::DIST_W-1:0]  right_cm;

   modport source (output valid, output front_cm, output left_cm, output right_cm,
                   input ready);
   modport sink   (input valid, input front_cm, input left_cm, input right_cm,
                   output ready);
endinterface

interface maze_bt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [maze_bt_pkg::MOVE_W-1:0]  move;
   logic                            finished;
   logic                            log_overflow;
   logic                            last;

   modport source (output valid, output move, output finished, output log_overflow,
                   output last, input ready);
   modport sink   (input valid, input move, input finished, input log_overflow,
                   input last, output ready);
endinterface

[hdl/maze_bt_ram.sv]
// ----------------------------------------------------------------------------
// maze_bt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module maze_bt_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = maze_bt_pkg::LOG_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/maze_explorer_backtracker.sv]
// ----------------------------------------------------------------------------
// maze_explorer_backtracker
// depth-first maze explorer with a move log and a junction stack
// ----------------------------------------------------------------------------
// Each request transaction carries front, left and right wall distances; each
// is classed far, open or blocked against the two limit registers, and the
// block answers with one or more response transactions (move codes), the
// final one flagged last. Forward is tried first, then left, then right;
// turns and forward steps go to the log ram and side openings push a junction
// onto the junction ram. With nothing left to explore the block turns
// around, replays the inverse moves back to the newest junction and turns
// into its next branch. Items are handled one at a time. A backtrack
// replays the log with one log ram read per cycle, and a stall on the
// response side holds any item, the replay included. Both rams start
// clear through per-entry valid bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module maze_explorer_backtracker #(
   parameter int LOG_DEPTH      = maze_bt_pkg::LOG_DEPTH_DEF,
   parameter int JUNCTION_DEPTH = maze_bt_pkg::JUNCTION_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   maze_bt_req_if.sink                         req_bus,
   maze_bt_rsp_if.source                       rsp_bus,
   input  logic                                csr_we,
   input  logic [maze_bt_pkg::CSR_IDX_W-1:0]   csr_idx,
   input  logic [maze_bt_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // step count holds 0..LOG_DEPTH, junction entries keep a step count and a mark
   localparam int SC_W = $clog2(LOG_DEPTH + 1);
   localparam int LA_W = $clog2(LOG_DEPTH);
   localparam int JA_W = $clog2(JUNCTION_DEPTH);
   localparam int JW_W = SC_W + 2;
   localparam logic [SC_W-1:0] SC_MAX = SC_W'(LOG_DEPTH);
   localparam logic [JA_W-1:0] JT_MAX = JA_W'(JUNCTION_DEPTH - 1);
   localparam logic [maze_bt_pkg::RES_CNT_W-1:0] RES_MAX =
      maze_bt_pkg::RES_CNT_W'(maze_bt_pkg::MAX_RESULTS);

   // sequencer
   maze_bt_pkg::state_type state_ff, state_in;

   // limit registers
   logic [maze_bt_pkg::DIST_W-1:0] blk_lim_ff, blk_lim_in;
   logic [maze_bt_pkg::DIST_W-1:0] far_lim_ff, far_lim_in;

   // classified sides of the current transaction
   maze_bt_pkg::class_type cf_ff, cf_in;
   maze_bt_pkg::class_type cl_ff, cl_in;
   maze_bt_pkg::class_type cr_ff, cr_in;
   maze_bt_pkg::move_type  turn_ff, turn_in;

   // explorer scalars
   logic [SC_W-1:0] sc_ff, sc_in;
   logic [JA_W-1:0] jtop_ff, jtop_in;
   logic            done_ff, done_in;
   logic            ovf_ff, ovf_in;

   // valid bits standing in for the cleared ram contents
   logic [LOG_DEPTH-1:0]      log_vld_ff, log_vld_in;
   logic [JUNCTION_DEPTH-1:0] jun_vld_ff, jun_vld_in;
   logic                      log_rd_vld_ff, log_rd_vld_in;
   logic                      jun_rd_vld_ff, jun_rd_vld_in;

   // result counting and the one-deep hold that lets the last flag be placed
   logic [maze_bt_pkg::RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic                  pend_vld_ff, pend_vld_in;
   maze_bt_pkg::move_type pend_move_ff, pend_move_in;
   logic                  pend_fin_ff, pend_fin_in;
   logic                  pend_ovf_ff, pend_ovf_in;

   // response output register
   logic                  rsp_vld_ff, rsp_vld_in;
   maze_bt_pkg::move_type rsp_move_ff, rsp_move_in;
   logic                  rsp_fin_ff, rsp_fin_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;
   logic                  rsp_last_ff, rsp_last_in;

   // ram ports
   logic             log_we;
   logic [LA_W-1:0]  log_waddr;
   logic [1:0]       log_wdata;
   logic [LA_W-1:0]  log_raddr;
   logic [1:0]       log_rdata;
   logic [SC_W-1:0]  log_ridx;
   logic             jun_we;
   logic [JA_W-1:0]  jun_waddr;
   logic [JW_W-1:0]  jun_wdata;
   logic [JW_W-1:0]  jun_rdata;

   // decode of the read data
   logic [JW_W-1:0]           jun_word;
   logic [SC_W-1:0]           j_start;
   maze_bt_pkg::mark_type     j_mark;
   maze_bt_pkg::log_code_type log_m;

   // decision terms
   logic req_acc;
   logic out_free;
   logic cnt_full;
   logic at_junc;
   logic far2;
   logic all_far;
   logic go_fwd;
   logic go_left;
   logic go_right;
   logic do_pop;

   // emit control
   logic                  emit_req;
   maze_bt_pkg::move_type emit_move;
   logic                  emit_go;

   // action helpers
   logic                      push;
   maze_bt_pkg::mark_type     push_mark;
   logic                      rec;
   maze_bt_pkg::log_code_type rec_code;

   // ---------------------------------------------------------------- memories

   // move log, addressed by step count
   maze_bt_ram #(
      .WIDTH (2),
      .DEPTH (LOG_DEPTH)
   ) u_log_ram (
      .clock   (clock),
      .wr_en   (log_we),
      .wr_addr (log_waddr),
      .wr_data (log_wdata),
      .rd_addr (log_raddr),
      .rd_data (log_rdata)
   );

   // junction stack: start step count and explored mark, addressed by stack top
   maze_bt_ram #(
      .WIDTH (JW_W),
      .DEPTH (JUNCTION_DEPTH)
   ) u_jun_ram (
      .clock   (clock),
      .wr_en   (jun_we),
      .wr_addr (jun_waddr),
      .wr_data (jun_wdata),
      .rd_addr (jtop_ff),
      .rd_data (jun_rdata)
   );

   // ------------------------------------------------------------ handshakes

   assign req_bus.ready = (state_ff == maze_bt_pkg::ST_IDLE);
   assign req_acc       = req_bus.valid && req_bus.ready;

   // output register can take a new transaction this cycle
   assign out_free = !rsp_vld_ff || rsp_bus.ready;
   assign cnt_full = (res_cnt_ff == RES_MAX);

   assign rsp_bus.valid        = rsp_vld_ff;
   assign rsp_bus.move         = rsp_move_ff;
   assign rsp_bus.finished     = rsp_fin_ff;
   assign rsp_bus.log_overflow = rsp_ovf_ff;
   assign rsp_bus.last         = rsp_last_ff;

   // ------------------------------------------------------------ read decode

   // entries never written read as zero
   assign jun_word = jun_rd_vld_ff ? jun_rdata : '0;
   assign j_start  = jun_word[JW_W-1:2];
   assign j_mark   = maze_bt_pkg::mark_type'(jun_word[1:0]);
   assign log_m    = log_rd_vld_ff ? maze_bt_pkg::log_code_type'(log_rdata)
                                   : maze_bt_pkg::LG_NONE;

   // junction data is the entry at the stack top, read during the accept cycle
   assign at_junc  = (sc_ff == j_start);
   assign far2     = (cf_ff == maze_bt_pkg::CL_FAR) &&
                     ((cl_ff == maze_bt_pkg::CL_FAR) || (cr_ff == maze_bt_pkg::CL_FAR));
   assign all_far  = far2 && (cl_ff == maze_bt_pkg::CL_FAR) &&
                     (cr_ff == maze_bt_pkg::CL_FAR);
   assign go_fwd   = (cf_ff != maze_bt_pkg::CL_BLOCKED) &&
                     (!at_junc || (j_mark == maze_bt_pkg::MK_NONE));
   assign go_left  = (cl_ff != maze_bt_pkg::CL_BLOCKED) &&
                     (!at_junc || (j_mark inside {maze_bt_pkg::MK_NONE,
                                                  maze_bt_pkg::MK_FWD}));
   assign go_right = (cr_ff != maze_bt_pkg::CL_BLOCKED) &&
                     (!at_junc || (j_mark != maze_bt_pkg::MK_RIGHT));
   // junction fully explored: drop it from the stack
   assign do_pop   = ((j_mark == maze_bt_pkg::MK_LEFT) &&
                      (cr_ff == maze_bt_pkg::CL_BLOCKED)) ||
                     (j_mark == maze_bt_pkg::MK_RIGHT);

   // ------------------------------------------------------------ emit select

   always_comb begin
      emit_req  = 1'b0;
      emit_move = maze_bt_pkg::MV_NONE;
      case (state_ff)
         maze_bt_pkg::ST_NONE: begin
            emit_req = 1'b1;
         end
         maze_bt_pkg::ST_TURN: begin
            emit_req  = 1'b1;
            emit_move = turn_ff;
         end
         maze_bt_pkg::ST_FWD: begin
            emit_req  = 1'b1;
            emit_move = maze_bt_pkg::MV_FWD;
         end
         maze_bt_pkg::ST_BT_START: begin
            emit_req  = 1'b1;
            emit_move = maze_bt_pkg::MV_BACK;
         end
         maze_bt_pkg::ST_BT_LOOP: begin
            // replay the inverse of each logged move, empty entries give nothing
            if (sc_ff > j_start) begin
               case (log_m)
                  maze_bt_pkg::LG_FWD: begin
                     emit_req  = 1'b1;
                     emit_move = maze_bt_pkg::MV_FWD;
                  end
                  maze_bt_pkg::LG_LEFT: begin
                     emit_req  = 1'b1;
                     emit_move = maze_bt_pkg::MV_RIGHT;
                  end
                  maze_bt_pkg::LG_RIGHT: begin
                     emit_req  = 1'b1;
                     emit_move = maze_bt_pkg::MV_LEFT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         maze_bt_pkg::ST_BT_SRD: begin
            // step back into the junction cell
            if (log_m == maze_bt_pkg::LG_FWD) begin
               emit_req  = 1'b1;
               emit_move = maze_bt_pkg::MV_FWD;
            end
         end
         maze_bt_pkg::ST_BT_TAIL: begin
            // reorient into the next branch of the junction
            case (log_m)
               maze_bt_pkg::LG_FWD: begin
                  emit_req  = 1'b1;
                  emit_move = maze_bt_pkg::MV_BACK;
               end
               maze_bt_pkg::LG_LEFT: begin
                  emit_req  = 1'b1;
                  emit_move = maze_bt_pkg::MV_LEFT;
               end
               maze_bt_pkg::LG_RIGHT: begin
                  emit_req  = 1'b1;
                  emit_move = maze_bt_pkg::MV_RIGHT;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // a result beyond the cap is dropped, otherwise the hold stage must be free
   // or able to pass its transaction on
   assign emit_go = !emit_req || cnt_full || !pend_vld_ff || out_free;

   // ------------------------------------------------------------ next state

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         maze_bt_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = done_ff ? maze_bt_pkg::ST_NONE : maze_bt_pkg::ST_DECIDE;
            end
         end
         maze_bt_pkg::ST_DECIDE: begin
            if (far2) begin
               state_in = maze_bt_pkg::ST_NONE;
            end else if (go_fwd) begin
               state_in = maze_bt_pkg::ST_FWD;
            end else if (go_left || go_right) begin
               state_in = maze_bt_pkg::ST_TURN;
            end else begin
               state_in = maze_bt_pkg::ST_BT_WAIT;
            end
         end
         maze_bt_pkg::ST_NONE: begin
            if (emit_go) state_in = maze_bt_pkg::ST_FINISH;
         end
         maze_bt_pkg::ST_TURN: begin
            if (emit_go) state_in = maze_bt_pkg::ST_FWD;
         end
         maze_bt_pkg::ST_FWD: begin
            if (emit_go) state_in = maze_bt_pkg::ST_FINISH;
         end
         maze_bt_pkg::ST_BT_WAIT: begin
            state_in = maze_bt_pkg::ST_BT_START;
         end
         maze_bt_pkg::ST_BT_START: begin
            if (emit_go) state_in = maze_bt_pkg::ST_BT_LOOP;
         end
         maze_bt_pkg::ST_BT_LOOP: begin
            if (sc_ff <= j_start) state_in = maze_bt_pkg::ST_BT_SRD;
         end
         maze_bt_pkg::ST_BT_SRD: begin
            if (emit_go) state_in = maze_bt_pkg::ST_BT_TAIL;
         end
         maze_bt_pkg::ST_BT_TAIL: begin
            if (emit_go) state_in = maze_bt_pkg::ST_FINISH;
         end
         maze_bt_pkg::ST_FINISH: begin
            if (out_free) state_in = maze_bt_pkg::ST_IDLE;
         end
         default: begin
            state_in = maze_bt_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------ actions

   always_comb begin
      blk_lim_in   = blk_lim_ff;
      far_lim_in   = far_lim_ff;
      cf_in        = cf_ff;
      cl_in        = cl_ff;
      cr_in        = cr_ff;
      turn_in      = turn_ff;
      sc_in        = sc_ff;
      jtop_in      = jtop_ff;
      done_in      = done_ff;
      ovf_in       = ovf_ff;
      log_vld_in   = log_vld_ff;
      jun_vld_in   = jun_vld_ff;
      res_cnt_in   = res_cnt_ff;
      pend_vld_in  = pend_vld_ff;
      pend_move_in = pend_move_ff;
      pend_fin_in  = pend_fin_ff;
      pend_ovf_in  = pend_ovf_ff;
      rsp_vld_in   = rsp_vld_ff;
      rsp_move_in  = rsp_move_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      log_we       = 1'b0;
      log_waddr    = sc_ff[LA_W-1:0];
      log_wdata    = maze_bt_pkg::LG_NONE;
      jun_we       = 1'b0;
      jun_waddr    = jtop_ff;
      jun_wdata    = '0;
      push         = 1'b0;
      push_mark    = maze_bt_pkg::MK_NONE;
      rec          = 1'b0;
      rec_code     = maze_bt_pkg::LG_FWD;

      // the user makes limit writes only while idle; the block itself leaves this unchecked
      if (csr_we) begin
         case (csr_idx)
            maze_bt_pkg::CSR_BLOCKED_LIMIT: blk_lim_in = csr_wdata;
            maze_bt_pkg::CSR_FAR_LIMIT:     far_lim_in = csr_wdata;
            default: begin
            end
         endcase
      end

      // output register drains
      if (rsp_vld_ff && rsp_bus.ready) begin
         rsp_vld_in = 1'b0;
      end

      // new result goes to the hold stage, the held one moves out as not last
      if (emit_req && emit_go && !cnt_full) begin
         if (pend_vld_ff) begin
            rsp_vld_in  = 1'b1;
            rsp_move_in = pend_move_ff;
            rsp_fin_in  = pend_fin_ff;
            rsp_ovf_in  = pend_ovf_ff;
            rsp_last_in = 1'b0;
         end
         pend_vld_in  = 1'b1;
         pend_move_in = emit_move;
         pend_fin_in  = done_ff;
         pend_ovf_in  = ovf_ff;
         res_cnt_in   = res_cnt_ff + 1'b1;
      end

      case (state_ff)
         maze_bt_pkg::ST_IDLE: begin
            if (req_acc) begin
               cf_in      = maze_bt_pkg::classify(req_bus.front_cm, blk_lim_ff, far_lim_ff);
               cl_in      = maze_bt_pkg::classify(req_bus.left_cm, blk_lim_ff, far_lim_ff);
               cr_in      = maze_bt_pkg::classify(req_bus.right_cm, blk_lim_ff, far_lim_ff);
               res_cnt_in = '0;
            end
         end
         maze_bt_pkg::ST_DECIDE: begin
            if (far2) begin
               // all three far ends the maze: clear the log entry at the step count, stop
               if (all_far) begin
                  done_in = 1'b1;
                  if (sc_ff < SC_MAX) log_vld_in[sc_ff[LA_W-1:0]] = 1'b0;
               end
            end else if (go_fwd) begin
               push = (cl_ff == maze_bt_pkg::CL_OPEN) || (cr_ff == maze_bt_pkg::CL_OPEN);
            end else if (go_left) begin
               turn_in = maze_bt_pkg::MV_LEFT;
               push    = (cr_ff == maze_bt_pkg::CL_OPEN);
            end else if (go_right) begin
               turn_in = maze_bt_pkg::MV_RIGHT;
            end else if (do_pop) begin
               jun_we     = 1'b1;
               jun_waddr  = jtop_ff;
               jun_wdata  = {j_start, maze_bt_pkg::MK_NONE};
               jun_vld_in[jtop_ff] = 1'b1;
               if (jtop_ff != '0) jtop_in = jtop_ff - 1'b1;
            end
         end
         maze_bt_pkg::ST_TURN: begin
            rec      = emit_go;
            rec_code = (turn_ff == maze_bt_pkg::MV_LEFT) ? maze_bt_pkg::LG_LEFT
                                                         : maze_bt_pkg::LG_RIGHT;
         end
         maze_bt_pkg::ST_FWD: begin
            rec      = emit_go;
            rec_code = maze_bt_pkg::LG_FWD;
         end
         maze_bt_pkg::ST_BT_START: begin
            if (emit_go && (sc_ff != '0)) sc_in = sc_ff - 1'b1;
         end
         maze_bt_pkg::ST_BT_LOOP: begin
            if ((sc_ff > j_start) && emit_go) sc_in = sc_ff - 1'b1;
         end
         maze_bt_pkg::ST_BT_TAIL: begin
            if (emit_go && (log_m != maze_bt_pkg::LG_NONE)) begin
               jun_we    = 1'b1;
               jun_waddr = jtop_ff;
               jun_wdata = {j_start, log_m};
               jun_vld_in[jtop_ff] = 1'b1;
            end
         end
         maze_bt_pkg::ST_FINISH: begin
            // the held result is the final one of this transaction
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_move_in = pend_move_ff;
               rsp_fin_in  = pend_fin_ff;
               rsp_ovf_in  = pend_ovf_ff;
               rsp_last_in = 1'b1;
               pend_vld_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // junction push saturates at the top entry and keeps its mark there;
      // entries above the top always hold an unexplored mark
      if (push) begin
         if (jtop_ff < JT_MAX) begin
            jtop_in   = jtop_ff + 1'b1;
            push_mark = maze_bt_pkg::MK_NONE;
         end else begin
            jtop_in   = jtop_ff;
            push_mark = j_mark;
         end
         jun_we     = 1'b1;
         jun_waddr  = jtop_in;
         jun_wdata  = {sc_ff, push_mark};
         jun_vld_in[jtop_in] = 1'b1;
      end

      // log a move, or flag the overflow once the log is full
      if (rec) begin
         if (sc_ff < SC_MAX) begin
            log_we    = 1'b1;
            log_waddr = sc_ff[LA_W-1:0];
            log_wdata = rec_code;
            log_vld_in[sc_ff[LA_W-1:0]] = 1'b1;
            sc_in     = sc_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end

      // log read otherwise follows the next step count, so read data matches
      // the current one; the junction start entry is read instead when leaving
      // the replay loop or while waiting to step back into the junction
      log_ridx = sc_in;
      if ((state_ff == maze_bt_pkg::ST_BT_LOOP) && (sc_ff <= j_start)) begin
         log_ridx = j_start;
      end
      if ((state_ff == maze_bt_pkg::ST_BT_SRD) && !emit_go) begin
         log_ridx = j_start;
      end
      log_raddr     = log_ridx[LA_W-1:0];
      log_rd_vld_in = (log_ridx < SC_MAX) && log_vld_ff[log_raddr];
      jun_rd_vld_in = jun_vld_ff[jtop_ff];
   end

   // ------------------------------------------------------------ registers

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= maze_bt_pkg::ST_IDLE;
         blk_lim_ff    <= maze_bt_pkg::BLOCKED_LIMIT_RST;
         far_lim_ff    <= maze_bt_pkg::FAR_LIMIT_RST;
         sc_ff         <= '0;
         jtop_ff       <= '0;
         done_ff       <= 1'b0;
         ovf_ff        <= 1'b0;
         log_vld_ff    <= '0;
         jun_vld_ff    <= '0;
         log_rd_vld_ff <= 1'b0;
         jun_rd_vld_ff <= 1'b0;
         res_cnt_ff    <= '0;
         pend_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         blk_lim_ff    <= blk_lim_in;
         far_lim_ff    <= far_lim_in;
         sc_ff         <= sc_in;
         jtop_ff       <= jtop_in;
         done_ff       <= done_in;
         ovf_ff        <= ovf_in;
         log_vld_ff    <= log_vld_in;
         jun_vld_ff    <= jun_vld_in;
         log_rd_vld_ff <= log_rd_vld_in;
         jun_rd_vld_ff <= jun_rd_vld_in;
         res_cnt_ff    <= res_cnt_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      cf_ff        <= cf_in;
      cl_ff        <= cl_in;
      cr_ff        <= cr_in;
      turn_ff      <= turn_in;
      pend_move_ff <= pend_move_in;
      pend_fin_ff  <= pend_fin_in;
      pend_ovf_ff  <= pend_ovf_in;
      rsp_move_ff  <= rsp_move_in;
      rsp_fin_ff   <= rsp_fin_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ------------------------------------------------------------ assertions

   // step count never passes the log depth
   a_sc_bound: assert property (@(posedge clock) disable iff (reset)
      sc_ff <= SC_MAX)
      else $error("step count beyond log depth");

   // result count never passes the cap
   a_res_bound: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff <= RES_MAX)
      else $error("result count beyond cap");

   // a finished run stays finished
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("finished flag dropped");

   // overflow only comes up with a full log
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> (sc_ff == SC_MAX))
      else $error("overflow flagged with room in the log");

   // leaving the finish state puts out the last transaction of the item
   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == maze_bt_pkg::ST_FINISH) && out_free) |=> (rsp_vld_ff && rsp_last_ff))
      else $error("item closed without a last transaction");

endmodule
